>>> src/pkac_pkg.sv
package pkac_pkg;

  // Default sizes
  localparam int DEF_NUM_CELLS  = 4;
  localparam int DEF_ID_BITS    = 16;
  localparam int DEF_COUNT_BITS = 32;

  // Scanned identifier range is [SCAN_FIRST, SCAN_END)
  localparam int SCAN_FIRST = 10;
  localparam int SCAN_END   = 65524;

  localparam int TTI_BITS = 14;

  // Command codes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [1:0]          cell_req;
    logic [15:0]         rnti;
    logic                is_downlink;
    logic [TTI_BITS-1:0] tti;
  } in_word_t;

  typedef struct packed {
    logic [15:0] top_total_id;
    logic [31:0] top_total_count;
    logic [15:0] top_down_id;
    logic [31:0] top_down_count;
    logic [15:0] top_up_id;
    logic [31:0] top_up_count;
  } out_word_t;

endpackage

>>> src/per_key_activity_counter_argmax.sv
// Channel  Direction  Handshake              Word
// in       receive    in_valid / in_stall    pkac_pkg::in_word_t
// out      send       out_valid / out_stall  pkac_pkg::out_word_t
//
// A record word takes one read of the entry memory and one write back.
// For a query word the scan reads one identifier per cycle through the single
// memory read port.
// After reset a clearing pass writes NUM_CELLS * 2^ID_BITS entries (262144 at
// default sizes), one per cycle, with in_stall high.
// A finished result waits in the output register while the next word is taken.
module per_key_activity_counter_argmax #(
  parameter int NUM_CELLS  = pkac_pkg::DEF_NUM_CELLS,
  parameter int ID_BITS    = pkac_pkg::DEF_ID_BITS,
  parameter int COUNT_BITS = pkac_pkg::DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pkac_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pkac_pkg::out_word_t out_data
);
  import pkac_pkg::*;

  localparam int ID_SPACE  = 1 << ID_BITS;
  localparam int DEPTH     = NUM_CELLS * ID_SPACE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int SCAN_LAST = (ID_SPACE < SCAN_END) ? ID_SPACE - 1 : SCAN_END - 1;

  typedef struct packed {
    logic [COUNT_BITS-1:0] total;
    logic [COUNT_BITS-1:0] down;
    logic [COUNT_BITS-1:0] up;
    logic [TTI_BITS-1:0]   first_seen;
    logic [TTI_BITS-1:0]   last_seen;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REC,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  function automatic logic [ADDR_W-1:0] make_addr(logic [1:0] c, logic [ID_BITS-1:0] i);
    return ADDR_W'({1'b0, c, i});
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  state_t                state;
  logic [ADDR_W-1:0]     clr_addr;
  logic [ADDR_W-1:0]     rec_addr;
  logic                  rec_dl;
  logic [TTI_BITS-1:0]   rec_tti;
  logic [1:0]            scan_cell;
  logic [ID_BITS-1:0]    scan_id;
  logic                  cmp_vld;
  logic [ID_BITS-1:0]    cmp_id;
  logic [ID_BITS-1:0]    best_total_id;
  logic [COUNT_BITS-1:0] best_total;
  logic [ID_BITS-1:0]    best_down_id;
  logic [COUNT_BITS-1:0] best_down;
  logic [ID_BITS-1:0]    best_up_id;
  logic [COUNT_BITS-1:0] best_up;

  entry_t                mem [DEPTH];
  entry_t                rd_entry;
  entry_t                wr_entry;
  entry_t                rec_entry;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [ADDR_W-1:0]     mem_raddr;

  logic                  in_take;
  logic                  cell_ok;
  logic                  out_free;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign cell_ok  = ({2'b00, in_data.cell_req} < 4'(NUM_CELLS));
  assign out_free = !out_valid || !out_stall;

  // Build the updated entry for a record word
  always_comb begin
    rec_entry.total      = sat_inc(rd_entry.total);
    rec_entry.down       = rec_dl ? sat_inc(rd_entry.down) : rd_entry.down;
    rec_entry.up         = rec_dl ? rd_entry.up : sat_inc(rd_entry.up);
    rec_entry.first_seen = (rd_entry.total == '0) ? rec_tti : rd_entry.first_seen;
    rec_entry.last_seen  = rec_tti;
  end

  // Steer the memory ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rec_addr;
    wr_entry  = rec_entry;
    mem_raddr = make_addr(scan_cell, scan_id);
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        wr_entry  = '0;
      end
      S_IDLE: begin
        mem_raddr = make_addr(in_data.cell_req, in_data.rnti[ID_BITS-1:0]);
      end
      S_REC: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= wr_entry;
    end
    rd_entry <= mem[mem_raddr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      rec_addr  <= make_addr(in_data.cell_req, in_data.rnti[ID_BITS-1:0]);
      rec_dl    <= in_data.is_downlink;
      rec_tti   <= in_data.tti;
      scan_cell <= in_data.cell_req;
    end
    cmp_id <= scan_id;
  end

  // Control state, scan tracking and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      scan_id       <= '0;
      cmp_vld       <= 1'b0;
      out_valid     <= 1'b0;
      out_data      <= '0;
      best_total_id <= '0;
      best_total    <= '0;
      best_down_id  <= '0;
      best_down     <= '0;
      best_up_id    <= '0;
      best_up       <= '0;
    end else begin
      // drop the result once taken; the finish step loads the next one itself
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      cmp_vld <= (state == S_SCAN);

      // fold the word read last cycle into the running maxima
      if (cmp_vld) begin
        if (rd_entry.total > best_total) begin
          best_total    <= rd_entry.total;
          best_total_id <= cmp_id;
        end
        if (rd_entry.down > best_down) begin
          best_down    <= rd_entry.down;
          best_down_id <= cmp_id;
        end
        if (rd_entry.up > best_up) begin
          best_up    <= rd_entry.up;
          best_up_id <= cmp_id;
        end
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            if (in_data.cmd == CMD_QUERY) begin
              best_total_id <= '0;
              best_total    <= '0;
              best_down_id  <= '0;
              best_down     <= '0;
              best_up_id    <= '0;
              best_up       <= '0;
              scan_id       <= ID_BITS'(SCAN_FIRST);
              state         <= cell_ok ? S_SCAN : S_FIN;
            end else if (cell_ok) begin
              state <= S_REC;
            end
          end
        end
        S_REC: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_id == ID_BITS'(SCAN_LAST)) begin
            state <= S_DRAIN;
          end else begin
            scan_id <= scan_id + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid                <= 1'b1;
            out_data.top_total_id    <= 16'(best_total_id);
            out_data.top_total_count <= 32'(best_total);
            out_data.top_down_id     <= 16'(best_down_id);
            out_data.top_down_count  <= 32'(best_down);
            out_data.top_up_id       <= 16'(best_up_id);
            out_data.top_up_count    <= 32'(best_up);
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A new result only comes from the finish step
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) |-> $past(state == S_FIN)))
    else $error("result raised outside finish step");

  // Memory writes only during clearing or record write-back
  a_we_src: assert property (@(posedge clk) disable iff (rst)
    (mem_we |-> (state == S_CLEAR || state == S_REC)))
    else $error("unexpected memory write");

  // Running maxima never drop while scanning
  a_best_mono: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN && $past(state == S_SCAN)) |->
      (best_total >= $past(best_total) && best_down >= $past(best_down) &&
       best_up >= $past(best_up))))
    else $error("scan maximum decreased");

  // A record write-back always leaves a nonzero total
  a_rec_nonzero: assert property (@(posedge clk) disable iff (rst)
    ((state == S_REC) |-> (wr_entry.total != '0)))
    else $error("record wrote zero total");

  // Input is closed through the whole clearing pass
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    ((state == S_CLEAR && $past(state == S_CLEAR)) |-> (in_stall && !out_valid)))
    else $error("activity during clearing pass");

endmodule
